@@ src/zpt_pkg.sv @@
// Shared types, constants and codes for the zigzag pivot tracker.
package zpt_pkg;

  localparam int PRICE_BITS_DEF    = 32;
  localparam int GAP_FRAC_BITS_DEF = 16;

  localparam int FIELD_W    = 32;
  localparam int GAP_W      = 16;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int OUT_DATA_W = 2 * FIELD_W;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [GAP_W-1:0]     GAP_RESET        = 16'd3277;
  localparam logic [REG_IDX_W-1:0] REG_GAP_FRACTION = 1'b0;

  localparam int FQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  typedef enum logic [0:0] {
    REQ_CANDLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    ACT_REPLACE = 1'b0,
    ACT_APPEND  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_t;

  typedef enum logic [0:0] {
    PH_EVAL   = 1'b0,
    PH_COMMIT = 1'b1
  } phase_t;

  typedef struct packed {
    req_t               req;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] hi;
    logic [FIELD_W-1:0] lo;
  } cand_t;

  typedef struct packed {
    action_t            action;
    logic [FIELD_W-1:0] idx;
    logic [FIELD_W-1:0] price;
    logic               peak;
    logic               last;
  } pivot_t;

  typedef struct packed {
    logic   push0;
    logic   push1;
    pivot_t res0;
    pivot_t res1;
  } push_t;

endpackage

@@ src/zpt_front.sv @@
// Front end: decode incoming items and hold them in a short queue.
module zpt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_tuser,  // req_type
  input  logic [zpt_pkg::IN_DATA_W-1:0] in_tdata, // candle_index, high_price, low_price
  output logic                         head_valid,
  output zpt_pkg::cand_t               head,
  input  logic                         pop
);

  localparam int AW = $clog2(zpt_pkg::FQ_DEPTH);

  zpt_pkg::cand_t mem_r [zpt_pkg::FQ_DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]    cnt_r, cnt_nxt;
  zpt_pkg::cand_t incoming;
  logic           push, take;

  // Classify: split the packed beat into request kind and candle fields
  always_comb begin
    incoming.req = zpt_pkg::req_t'(in_tuser);
    incoming.idx = in_tdata[zpt_pkg::FIELD_W-1:0];
    incoming.hi  = in_tdata[2*zpt_pkg::FIELD_W-1:zpt_pkg::FIELD_W];
    incoming.lo  = in_tdata[3*zpt_pkg::FIELD_W-1:2*zpt_pkg::FIELD_W];
  end

  assign in_tready  = (cnt_r != (AW+1)'(zpt_pkg::FQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign push       = in_tvalid && in_tready;
  assign take       = pop && head_valid;

  always_comb begin
    wp_nxt  = push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = take ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !take) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (take && !push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= incoming;
    end
  end

endmodule

@@ src/zpt_exec.sv @@
// Back end: pivot tracking state, reversal test and result generation.
module zpt_exec #(
  parameter int PRICE_BITS    = zpt_pkg::PRICE_BITS_DEF,
  parameter int GAP_FRAC_BITS = zpt_pkg::GAP_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     head_valid,
  input  zpt_pkg::cand_t           head,
  output logic                     pop,
  input  logic [zpt_pkg::GAP_W-1:0] gap,
  input  logic                     out_room,
  output zpt_pkg::push_t           push
);

  localparam int PW     = (PRICE_BITS < zpt_pkg::FIELD_W) ? PRICE_BITS : zpt_pkg::FIELD_W;
  localparam int PROD_W = zpt_pkg::GAP_W + PW;
  localparam int CMP_W  = PW + ((GAP_FRAC_BITS > zpt_pkg::GAP_W) ? GAP_FRAC_BITS
                                                                  : zpt_pkg::GAP_W);
  localparam int IW     = zpt_pkg::FIELD_W;

  typedef enum logic [3:0] {
    OP_NOP, OP_CLEAR, OP_INIT, OP_REPL_HI, OP_REPL_LO,
    OP_REV_DOWN, OP_REV_UP, OP_FIRST_HI, OP_FIRST_LO
  } op_t;

  // Tracking state
  zpt_pkg::trend_t trend_r, trend_nxt;
  logic            first_seen_r, first_seen_nxt;
  logic [PW-1:0]   fh_price_r, fh_price_nxt, fl_price_r, fl_price_nxt;
  logic [PW-1:0]   lp_price_r, lp_price_nxt;
  logic [IW-1:0]   fh_idx_r, fh_idx_nxt, fl_idx_r, fl_idx_nxt;
  zpt_pkg::phase_t phase_r, phase_nxt;

  // Evaluation stage registers
  op_t               op_r;
  logic [IW-1:0]     idx_r;
  logic [PW-1:0]     hi_r, lo_r, diff_r;
  logic              ok_r;
  logic [PROD_W-1:0] prod_r;

  op_t               op_c;
  logic [PW-1:0]     hi_c, lo_c, top_c, sub_c, base_c, diff_c;
  logic              ok_c, pass_c, commit;
  logic [PROD_W-1:0] prod_c;

  // Sequencer: evaluate one item, then commit it
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      zpt_pkg::PH_EVAL:   if (head_valid) phase_nxt = zpt_pkg::PH_COMMIT;
      zpt_pkg::PH_COMMIT: if (out_room)   phase_nxt = zpt_pkg::PH_EVAL;
      default:            phase_nxt = zpt_pkg::PH_EVAL;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    unique case (phase_r)
      zpt_pkg::PH_EVAL:   pop    = head_valid;
      zpt_pkg::PH_COMMIT: commit = out_room;
      default: ;
    endcase
  end

  // Pick the rule and the operands of the reversal test
  always_comb begin
    hi_c   = head.hi[PW-1:0];
    lo_c   = head.lo[PW-1:0];
    top_c  = '0;
    sub_c  = '0;
    base_c = '0;
    op_c   = OP_NOP;
    if (head.req == zpt_pkg::REQ_CLEAR) begin
      op_c = OP_CLEAR;
    end else begin
      case (trend_r)
        zpt_pkg::TREND_UP: begin
          if (hi_c > lp_price_r) begin
            op_c = OP_REPL_HI;
          end else begin
            op_c   = OP_REV_DOWN;
            top_c  = lp_price_r;
            sub_c  = lo_c;
            base_c = lp_price_r;
          end
        end
        zpt_pkg::TREND_DOWN: begin
          if (lo_c < lp_price_r) begin
            op_c = OP_REPL_LO;
          end else begin
            op_c   = OP_REV_UP;
            top_c  = hi_c;
            sub_c  = lp_price_r;
            base_c = hi_c;
          end
        end
        default: begin
          if (!first_seen_r) begin
            op_c = OP_INIT;
          end else if (hi_c > fh_price_r) begin
            op_c   = OP_FIRST_HI;
            top_c  = hi_c;
            sub_c  = fl_price_r;
            base_c = hi_c;
          end else if (lo_c < fl_price_r) begin
            op_c   = OP_FIRST_LO;
            top_c  = fh_price_r;
            sub_c  = lo_c;
            base_c = fh_price_r;
          end
        end
      endcase
    end
    diff_c = top_c - sub_c;
    ok_c   = (top_c >= sub_c) && (base_c != '0);
    prod_c = PROD_W'(gap) * PROD_W'(base_c);
  end

  // Finish the cross-multiplied test: diff * 2^frac >= gap * base
  assign pass_c = ok_r && ((CMP_W'(diff_r) << GAP_FRAC_BITS) >= CMP_W'(prod_r));

  always_comb begin
    trend_nxt      = trend_r;
    first_seen_nxt = first_seen_r;
    fh_price_nxt   = fh_price_r;
    fh_idx_nxt     = fh_idx_r;
    fl_price_nxt   = fl_price_r;
    fl_idx_nxt     = fl_idx_r;
    lp_price_nxt   = lp_price_r;
    push           = '0;
    if (commit) begin
      case (op_r)
        OP_CLEAR: begin
          trend_nxt      = zpt_pkg::TREND_NONE;
          first_seen_nxt = 1'b0;
          fh_price_nxt   = '0;
          fh_idx_nxt     = '0;
          fl_price_nxt   = '0;
          fl_idx_nxt     = '0;
          lp_price_nxt   = '0;
        end
        OP_INIT: begin
          first_seen_nxt = 1'b1;
          fh_price_nxt   = hi_r;
          fh_idx_nxt     = idx_r;
          fl_price_nxt   = lo_r;
          fl_idx_nxt     = idx_r;
        end
        OP_REPL_HI: begin
          lp_price_nxt = hi_r;
          push.push0   = 1'b1;
          push.res0    = '{zpt_pkg::ACT_REPLACE, idx_r, IW'(hi_r), 1'b1, 1'b1};
        end
        OP_REPL_LO: begin
          lp_price_nxt = lo_r;
          push.push0   = 1'b1;
          push.res0    = '{zpt_pkg::ACT_REPLACE, idx_r, IW'(lo_r), 1'b0, 1'b1};
        end
        OP_REV_DOWN: begin
          if (pass_c) begin
            lp_price_nxt = lo_r;
            trend_nxt    = zpt_pkg::TREND_DOWN;
            push.push0   = 1'b1;
            push.res0    = '{zpt_pkg::ACT_APPEND, idx_r, IW'(lo_r), 1'b0, 1'b1};
          end
        end
        OP_REV_UP: begin
          if (pass_c) begin
            lp_price_nxt = hi_r;
            trend_nxt    = zpt_pkg::TREND_UP;
            push.push0   = 1'b1;
            push.res0    = '{zpt_pkg::ACT_APPEND, idx_r, IW'(hi_r), 1'b1, 1'b1};
          end
        end
        OP_FIRST_HI: begin
          fh_price_nxt = hi_r;
          fh_idx_nxt   = idx_r;
          if (pass_c) begin
            trend_nxt    = zpt_pkg::TREND_UP;
            lp_price_nxt = hi_r;
            push.push0   = 1'b1;
            push.push1   = 1'b1;
            push.res0    = '{zpt_pkg::ACT_APPEND, fl_idx_r, IW'(fl_price_r), 1'b0, 1'b0};
            push.res1    = '{zpt_pkg::ACT_APPEND, idx_r, IW'(hi_r), 1'b1, 1'b1};
          end
        end
        OP_FIRST_LO: begin
          fl_price_nxt = lo_r;
          fl_idx_nxt   = idx_r;
          if (pass_c) begin
            trend_nxt    = zpt_pkg::TREND_DOWN;
            lp_price_nxt = lo_r;
            push.push0   = 1'b1;
            push.push1   = 1'b1;
            push.res0    = '{zpt_pkg::ACT_APPEND, fh_idx_r, IW'(fh_price_r), 1'b1, 1'b0};
            push.res1    = '{zpt_pkg::ACT_APPEND, idx_r, IW'(lo_r), 1'b0, 1'b1};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= zpt_pkg::PH_EVAL;
      trend_r      <= zpt_pkg::TREND_NONE;
      first_seen_r <= 1'b0;
      fh_price_r   <= '0;
      fh_idx_r     <= '0;
      fl_price_r   <= '0;
      fl_idx_r     <= '0;
      lp_price_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      trend_r      <= trend_nxt;
      first_seen_r <= first_seen_nxt;
      fh_price_r   <= fh_price_nxt;
      fh_idx_r     <= fh_idx_nxt;
      fl_price_r   <= fl_price_nxt;
      fl_idx_r     <= fl_idx_nxt;
      lp_price_r   <= lp_price_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_r   <= op_c;
      idx_r  <= head.idx;
      hi_r   <= hi_c;
      lo_r   <= lo_c;
      diff_r <= diff_c;
      ok_r   <= ok_c;
      prod_r <= prod_c;
    end
  end

endmodule

@@ src/zpt_out.sv @@
// Result queue: takes up to two pivots per cycle, drives the output stream.
module zpt_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  zpt_pkg::push_t                push,
  output logic                          out_room,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [zpt_pkg::OUT_DATA_W-1:0] out_tdata, // pivot_index, pivot_price
  output logic [1:0]                    out_tuser, // action, is_peak
  output logic                          out_tlast  // last_of_run
);

  localparam int AW = $clog2(zpt_pkg::OQ_DEPTH);

  zpt_pkg::pivot_t mem_r [zpt_pkg::OQ_DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt, n_in;
  zpt_pkg::pivot_t head;
  logic            take;

  assign head       = mem_r[rp_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {head.price, head.idx};
  assign out_tuser  = {head.peak, head.action};
  assign out_tlast  = head.last;
  assign take       = out_tvalid && out_tready;
  // Room for a full pair keeps the back end from splitting a run
  assign out_room   = (cnt_r <= (AW+1)'(zpt_pkg::OQ_DEPTH - 2));

  always_comb begin
    n_in    = (AW+1)'(push.push0) + (AW+1)'(push.push1);
    wp_nxt  = wp_r + n_in[AW-1:0];
    rp_nxt  = take ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + n_in - (AW+1)'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wp_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wp_r + AW'(1)] <= push.res1;
    end
  end

endmodule

@@ src/zigzag_pivot_tracker.sv @@
// Top level of the zigzag pivot tracker: config register, front, back, result queue.
//
// Usage:
//   in_*  : candle stream. tuser is req_type (clear request when high); tdata carries
//           candle_index, high_price, low_price from bit 0 up. A clear item returns
//           tracking to its reset state and yields no result; the gap setting is kept.
//   out_* : pivot stream. tdata carries pivot_index, pivot_price; tuser carries action
//           (replace or append) and is_peak; tlast marks the final pivot of an item.
//   cfg_* : APB-style port, one register: gap_fraction (Q0.16) at byte address 0.
//           Write only while the block is idle.
// Sequencing: the back end takes one item at a time; it evaluates an item (rule
//   select, difference, 16 x price multiply) in its evaluate phase and, once the result
//   queue has room, commits the reversal compare and state update in its commit phase.
// Path: an accepted item passes the input queue and the evaluate registers, and its
//   pivots are written to the result queue before out_tvalid rises.
// Stalls: a two-entry input queue and a four-entry result queue decouple the sides;
//   in_tready stays high while the input queue has space even if out_tready is low.
//   The back end commits only when the result queue has room for two pivots.
// Reset: rst_n (synchronous, active low) empties both queues, clears tracking state
//   and loads gap_fraction with its default.
module zigzag_pivot_tracker #(
  parameter int PRICE_BITS    = zpt_pkg::PRICE_BITS_DEF,
  parameter int GAP_FRAC_BITS = zpt_pkg::GAP_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // candle input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [zpt_pkg::IN_DATA_W-1:0]  in_tdata,  // candle_index, high_price, low_price
  input  logic                           in_tuser,  // req_type
  // pivot output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [zpt_pkg::OUT_DATA_W-1:0] out_tdata, // pivot_index, pivot_price
  output logic [1:0]                     out_tuser, // action, is_peak
  output logic                           out_tlast, // last_of_run
  // configuration
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [zpt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [zpt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [zpt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  logic [zpt_pkg::GAP_W-1:0]     gap_r, gap_nxt;
  logic [zpt_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;

  logic           head_valid, pop, out_room;
  zpt_pkg::cand_t head;
  zpt_pkg::push_t push;

  // Register index is the word address; byte offset bits are ignored
  assign reg_idx    = cfg_paddr[zpt_pkg::CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    gap_nxt    = gap_r;
    cfg_prdata = '0;
    if (reg_idx == zpt_pkg::REG_GAP_FRACTION) begin
      cfg_prdata = zpt_pkg::CFG_DATA_W'(gap_r);
      if (cfg_wr) begin
        gap_nxt = cfg_pwdata[zpt_pkg::GAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= zpt_pkg::GAP_RESET;
    end else begin
      gap_r <= gap_nxt;
    end
  end

  // Accept and classify candles
  zpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Track pivots
  zpt_exec #(
    .PRICE_BITS    (PRICE_BITS),
    .GAP_FRAC_BITS (GAP_FRAC_BITS)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .gap        (gap_r),
    .out_room   (out_room),
    .push       (push)
  );

  // Hold results until the receiver takes them
  zpt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .out_room   (out_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  // A replace never opens a pair of pivots
  a_replace_single : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] == zpt_pkg::ACT_REPLACE)) |-> out_tlast)
    else $error("replace result not marked last");

  // The second pivot of a pair is already queued and has the opposite kind
  a_pair_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && (out_tuser[1] != $past(out_tuser[1]))))
    else $error("pivot pair broken");

  // A register write to the gap_fraction index lands in the gap register
  a_gap_write : assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (reg_idx == zpt_pkg::REG_GAP_FRACTION)) |=>
      (gap_r == $past(cfg_pwdata[zpt_pkg::GAP_W-1:0])))
    else $error("gap register write lost");
`endif

endmodule

@@ bench/zigzag_pivot_tracker_check.sv @@
// Scoreboard for the zigzag pivot tracker: predicts pivots from accepted items and checks them.
module zigzag_pivot_tracker_check
  import zpt_pkg::*;
#(
  parameter int GAP_FRAC_BITS = GAP_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // candle_index, high_price, low_price
  input  logic                  in_tuser,   // req_type
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // pivot_index, pivot_price
  input  logic [1:0]            out_tuser,  // action, is_peak
  input  logic                  out_tlast,  // last_of_run
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    mismatches,
  output int                    pivots_owed,
  output int                    pivots_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the tracking state and the gap register.
  logic [GAP_W-1:0]   gap;
  trend_t             trend;
  logic               seen;
  logic [FIELD_W-1:0] top_price, top_idx, bottom_price, bottom_idx, pivot_price;

  pivot_t expected_pivots[$];
  int     fails  = 0;
  int     n_seen = 0;

  // True when (top - sub) / base reaches the gap, tested without division.
  function automatic logic clears_gap(input logic [FIELD_W-1:0] top, sub, base);
    logic [63:0] lhs, rhs;
    if (base == '0 || top < sub) return 1'b0;
    lhs = 64'(top - sub) << GAP_FRAC_BITS;
    rhs = 64'(gap) * 64'(base);
    return lhs >= rhs;
  endfunction

  function automatic pivot_t make_pivot(input action_t act, input logic [FIELD_W-1:0] idx,
                                        input logic [FIELD_W-1:0] price, input logic peak);
    pivot_t p;
    p.action = act;
    p.idx    = idx;
    p.price  = price;
    p.peak   = peak;
    p.last   = 1'b0;
    return p;
  endfunction

  task automatic forget_trend();
    trend        = TREND_NONE;
    seen         = 1'b0;
    top_price    = '0;
    top_idx      = '0;
    bottom_price = '0;
    bottom_idx   = '0;
    pivot_price  = '0;
  endtask

  // Advance the shadow state by one item and queue the pivots it produces.
  task automatic track_candle(input cand_t c);
    pivot_t run[$];
    pivot_t p;
    if (c.req == REQ_CLEAR) begin
      forget_trend();
      return;
    end
    case (trend)
      TREND_UP: begin
        if (c.hi > pivot_price) begin
          pivot_price = c.hi;
          run.push_back(make_pivot(ACT_REPLACE, c.idx, c.hi, 1'b1));
        end else if (clears_gap(pivot_price, c.lo, pivot_price)) begin
          pivot_price = c.lo;
          trend       = TREND_DOWN;
          run.push_back(make_pivot(ACT_APPEND, c.idx, c.lo, 1'b0));
        end
      end
      TREND_DOWN: begin
        if (c.lo < pivot_price) begin
          pivot_price = c.lo;
          run.push_back(make_pivot(ACT_REPLACE, c.idx, c.lo, 1'b0));
        end else if (clears_gap(c.hi, pivot_price, c.hi)) begin
          pivot_price = c.hi;
          trend       = TREND_UP;
          run.push_back(make_pivot(ACT_APPEND, c.idx, c.hi, 1'b1));
        end
      end
      default: begin
        // no trend yet: gather the first high and low until their spread clears the gap
        if (!seen) begin
          seen         = 1'b1;
          top_price    = c.hi;
          top_idx      = c.idx;
          bottom_price = c.lo;
          bottom_idx   = c.idx;
        end else if (c.hi > top_price) begin
          top_price = c.hi;
          top_idx   = c.idx;
          if (clears_gap(top_price, bottom_price, top_price)) begin
            trend       = TREND_UP;
            pivot_price = top_price;
            run.push_back(make_pivot(ACT_APPEND, bottom_idx, bottom_price, 1'b0));
            run.push_back(make_pivot(ACT_APPEND, top_idx, top_price, 1'b1));
          end
        end else if (c.lo < bottom_price) begin
          bottom_price = c.lo;
          bottom_idx   = c.idx;
          if (clears_gap(top_price, bottom_price, top_price)) begin
            trend       = TREND_DOWN;
            pivot_price = bottom_price;
            run.push_back(make_pivot(ACT_APPEND, top_idx, top_price, 1'b1));
            run.push_back(make_pivot(ACT_APPEND, bottom_idx, bottom_price, 1'b0));
          end
        end
      end
    endcase
    foreach (run[k]) begin
      p      = run[k];
      p.last = (k == run.size() - 1);
      expected_pivots.push_back(p);
    end
  endtask

  always @(posedge clk) begin : score
    cand_t  c;
    pivot_t got, want;
    if (!rst_n) begin
      gap = GAP_RESET;
      forget_trend();
      expected_pivots.delete();
      fails  = 0;
      n_seen = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && cfg_paddr[CFG_ADDR_W-1:2] == REG_GAP_FRACTION)
        gap = cfg_pwdata[GAP_W-1:0];
      if (in_tvalid && in_tready) begin
        c.req = req_t'(in_tuser);
        c.idx = in_tdata[FIELD_W-1:0];
        c.hi  = in_tdata[2*FIELD_W-1:FIELD_W];
        c.lo  = in_tdata[3*FIELD_W-1:2*FIELD_W];
        track_candle(c);
      end
      if (out_tvalid && out_tready) begin
        got = make_pivot(action_t'(out_tuser[0]), out_tdata[FIELD_W-1:0],
                         out_tdata[2*FIELD_W-1:FIELD_W], out_tuser[1]);
        got.last = out_tlast;
        if (expected_pivots.size() == 0) begin
          $error("unexpected pivot: index %0d price %0d", got.idx, got.price);
          fails++;
        end else begin
          want = expected_pivots.pop_front();
          n_seen++;
          if (got.action != want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            fails++;
          end
          if (got.idx != want.idx) begin
            $error("pivot_index: expected %0d, got %0d", want.idx, got.idx);
            fails++;
          end
          if (got.price != want.price) begin
            $error("pivot_price: expected %0d, got %0d", want.price, got.price);
            fails++;
          end
          if (got.peak != want.peak) begin
            $error("is_peak: expected %0d, got %0d", want.peak, got.peak);
            fails++;
          end
          if (got.last != want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, got.last);
            fails++;
          end
        end
      end
    end
    mismatches  <= fails;
    pivots_owed <= expected_pivots.size();
    pivots_seen <= n_seen;
  end

endmodule

@@ bench/zigzag_pivot_tracker_test.sv @@
// Top of the zigzag pivot tracker bench: clock, reset, stimulus, idling and the verdict.
module zigzag_pivot_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import zpt_pkg::*;

  // Share of cycles in which either side idles while not in a calm stretch.
  localparam int IDLE_PCT      = 33;
  // Two items can sit in the input queue and one in the back end without yielding a pivot,
  // so this many cycles after the last pivot leaves it truly idle.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 20;
  // Slowest correct run: a random stall on either side, plus a settle wait and a
  // register write; this limit is many times that.
  localparam int QUIET_LIMIT   = 2000;
  // No register lives at this index; writes to it must leave the gap untouched.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
  localparam int N_PHASES      = 7;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // candle_index, high_price, low_price
  logic                  in_tuser    = 1'b0; // req_type
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // pivot_index, pivot_price
  logic [1:0]            out_tuser;         // action, is_peak
  logic                  out_tlast;         // last_of_run
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int   mismatches, pivots_owed, pivots_seen;
  logic calm         = 1'b0;  // when set, neither side idles
  int   quiet_cycles = 0;
  int   n_items      = 0;
  int   n_clears     = 0;
  int   n_settings   = 1;     // the reset value counts as one setting

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  zigzag_pivot_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  zigzag_pivot_tracker_check pivot_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .mismatches (mismatches),
    .pivots_owed(pivots_owed),
    .pivots_seen(pivots_seen)
  );

  // Receiver: stall at random, except in calm stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[zigzag_pivot_tracker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, maybe after an idle gap, and hold it until the block takes it.
  // Valid stays high afterwards so back-to-back items never toggle it within a step.
  task automatic send_item(input req_t req, input logic [FIELD_W-1:0] idx, hi, lo);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {lo, hi, idx};
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (req == REQ_CLEAR) n_clears++;
  endtask

  // Drop valid and hold off until every predicted pivot has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pivots_owed != 0) @(posedge clk);
  endtask

  // Drain, then let items that produce no pivot finish inside the block.
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {which, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    if (which == REG_GAP_FRACTION) n_settings++;
  endtask

  initial begin : stimulus
    int unsigned        gap_plan [N_PHASES];
    int                 plan_len [N_PHASES];
    int                 hold_at, run_left, pick;
    logic [63:0]        mid, step, spread, hi64, lo64;
    logic               rising;
    logic [FIELD_W-1:0] idx_ctr, hi, lo;

    gap_plan    = '{3277, 655, 0, 13107, 0, 65535, 3277};
    gap_plan[4] = $urandom_range(1, 65534);
    plan_len    = '{250, 300, 200, 300, 200, 100, 200};
    run_left    = 0;
    mid         = 64'd1000;
    rising      = 1'b1;
    idx_ctr     = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset gap: build a trend and walk through each rule.
    send_item(REQ_CANDLE, 32'd0, 32'd1000, 32'd990);   // first candle: stored only
    send_item(REQ_CANDLE, 32'd1, 32'd1000, 32'd960);   // lower low, spread still short
    send_item(REQ_CANDLE, 32'd2, 32'd1100, 32'd1000);  // new high clears gap: two pivots
    send_item(REQ_CANDLE, 32'd3, 32'd1200, 32'd1150);  // higher high: replace peak
    send_item(REQ_CANDLE, 32'd4, 32'd1100, 32'd1300);  // low above high: negative difference
    send_item(REQ_CANDLE, 32'd5, 32'd1190, 32'd1100);  // reversal down: append trough
    send_item(REQ_CANDLE, 32'd6, 32'd1050, 32'd1000);  // lower low: replace trough
    send_item(REQ_CANDLE, 32'd7, 32'd0, 32'd1200);     // zero base in a down trend
    send_item(REQ_CANDLE, 32'd8, 32'd1100, 32'd1050);  // reversal up: append peak
    // Both directions in one candle at the price extremes; only the first rule acts.
    send_item(REQ_CANDLE, 32'd9, 32'hFFFF_FFFF, 32'd0);
    send_item(REQ_CANDLE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0);
    send_item(REQ_CLEAR, $urandom, $urandom, $urandom);
    send_item(REQ_CANDLE, 32'd0, 32'd0, 32'd0);        // first candle with zero prices
    send_item(REQ_CANDLE, 32'd1, 32'd5, 32'd0);        // up trend from a zero low
    send_item(REQ_CLEAR, 32'd0, 32'd0, 32'd0);
    send_item(REQ_CANDLE, 32'd100, 32'd2000, 32'd1990);
    send_item(REQ_CANDLE, 32'd101, 32'd1995, 32'd1500); // lower low clears gap: down trend

    // Zero gap: equal prices reverse, a negative difference still does not.
    settle();
    write_reg(REG_GAP_FRACTION, 32'd0);
    send_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(REQ_CANDLE, 32'd0, 32'd50, 32'd50);
    send_item(REQ_CANDLE, 32'd1, 32'd60, 32'd55);
    send_item(REQ_CANDLE, 32'd2, 32'd40, 32'd70);
    send_item(REQ_CANDLE, 32'd3, 32'd59, 32'd60);

    // Largest gap: only a swing whose low is about zero counts.
    settle();
    write_reg(REG_GAP_FRACTION, 32'd65535);
    send_item(REQ_CLEAR, 32'd0, 32'd0, 32'd0);
    send_item(REQ_CANDLE, 32'd7, 32'd1000, 32'd0);
    send_item(REQ_CANDLE, 32'd8, 32'd2000, 32'd10);

    settle();
    write_reg(REG_SPARE, $urandom);

    // Random part: price walks with random content, with some noise mixed in.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_reg(REG_GAP_FRACTION, gap_plan[ph]);
      calm    <= (ph == 1);
      hold_at  = $urandom_range(20, plan_len[ph] - 20);
      for (int k = 0; k < plan_len[ph]; k++) begin
        if (k == hold_at) drain();
        pick = $urandom_range(99);
        if (run_left == 0) begin
          // start a new walk at a random price scale and index
          run_left = $urandom_range(10, 60);
          mid      = 64'($urandom >> $urandom_range(0, 26));
          if (mid < 64'd16) mid = 64'd16;
          idx_ctr  = $urandom_range(1) ? $urandom : '0;
          rising   = 1'($urandom_range(1));
          if ($urandom_range(1)) pick = 0;
        end
        run_left--;
        if (pick < 4) begin
          send_item(REQ_CLEAR, $urandom, $urandom, $urandom);
        end else if (pick < 10) begin
          send_item(REQ_CANDLE, $urandom, $urandom, $urandom);
        end else begin
          // advance the walk; flip direction now and then
          if ($urandom_range(99) < 25) rising = !rising;
          step = (mid >> $urandom_range(1, 6)) * $urandom_range(0, 4) / 4;
          if (rising) mid = mid + step;
          else mid = (mid > step + 1) ? mid - step : 64'($urandom_range(1, 64));
          if (mid > 64'hFFFF_FFFF) mid = 64'hFFFF_FFFF - $urandom_range(0, 1023);
          spread  = mid >> $urandom_range(3, 9);
          hi64    = mid + spread;
          if (hi64 > 64'hFFFF_FFFF) hi64 = 64'hFFFF_FFFF;
          lo64    = mid - spread;
          idx_ctr = idx_ctr + 1;
          hi      = hi64[FIELD_W-1:0];
          lo      = lo64[FIELD_W-1:0];
          // swap now and then to feed a low above the high
          if (pick < 13) send_item(REQ_CANDLE, idx_ctr, lo, hi);
          else send_item(REQ_CANDLE, idx_ctr, hi, lo);
        end
      end
    end

    calm <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d items (%0d clears) over %0d gap settings;", n_items, n_clears,
             n_settings);
    $display("%0d pivots compared, %0d field mismatches.", pivots_seen, mismatches);
    if (mismatches == 0 && pivots_owed == 0) begin
      $display("[zigzag_pivot_tracker] OK");
    end else begin
      $display("[zigzag_pivot_tracker] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/zpt_pkg.sv
src/zpt_front.sv
src/zpt_exec.sv
src/zpt_out.sv
src/zigzag_pivot_tracker.sv
bench/zigzag_pivot_tracker_check.sv
bench/zigzag_pivot_tracker_test.sv
